@@ sv/mrrb_pkg.sv @@
// Shared types and codes for the multi-reader ring buffer.
// No dependencies; imported by mrrb_front, mrrb_back and multi_reader_ring_buffer.
package mrrb_pkg;

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_PEEK  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_OPEN  = 3'd3;
    localparam logic [2:0] OP_CLOSE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_OVERRUN  = 3'd2;
    localparam logic [2:0] ST_UNDERRUN = 3'd3;
    localparam logic [2:0] ST_NOFREE   = 3'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READERS  = 2'd1;

    localparam logic [3:0] CAPACITY_RESET = 4'd15;
    localparam logic [2:0] READERS_RESET  = 3'd4;

    typedef enum logic [2:0] {
        K_PUSH,
        K_PEEK,
        K_POP,
        K_OPEN,
        K_CLOSE,
        K_BAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [2:0] reader;
    } op_ctl_t;

    typedef struct packed {
        logic [3:0] capacity;
        logic [2:0] readers_in_use;
    } cfg_t;

endpackage

@@ sv/mrrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/mrrb_front.sv @@
// Front end: accepts requests, decodes the opcode and queues them for the back end.
// Depends on mrrb_pkg.
module mrrb_front #(
    parameter int DATA_W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [2:0]          reader,
    input  logic [DATA_W-1:0]   data_in,
    output logic                q_valid,
    input  logic                q_pop,
    output mrrb_pkg::op_ctl_t   q_ctl,
    output logic [DATA_W-1:0]   q_data
);
    import mrrb_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_ctl_t           ctl_reg  [DEPTH];
    logic [DATA_W-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;
    op_ctl_t           dec_ctl;

    always_comb
    begin
        dec_ctl.reader = reader;
        case (opcode)
            OP_PUSH:  dec_ctl.kind = K_PUSH;
            OP_PEEK:  dec_ctl.kind = K_PEEK;
            OP_POP:   dec_ctl.kind = K_POP;
            OP_OPEN:  dec_ctl.kind = K_OPEN;
            OP_CLOSE: dec_ctl.kind = K_CLOSE;
            default:  dec_ctl.kind = K_BAD;
        endcase
    end

    assign in_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_ctl    = ctl_reg[rd_ptr_reg];
    assign q_data   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_reg[wr_ptr_reg]  <= dec_ctl;
            data_reg[wr_ptr_reg] <= data_in;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("request queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("request queue count did not follow a lone push");
`endif

endmodule

@@ sv/mrrb_back.sv @@
// Back end: executes queued requests against reader state and the word RAM,
// and holds the result stage. Depends on mrrb_pkg and mrrb_ram.
module mrrb_back #(
    parameter int SLOTS   = 16,
    parameter int READERS = 4,
    parameter int DATA_W  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrrb_pkg::cfg_t      cfg,
    input  logic                q_valid,
    output logic                q_pop,
    input  mrrb_pkg::op_ctl_t   q_ctl,
    input  logic [DATA_W-1:0]   q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic [DATA_W-1:0]   data_out,
    output logic [1:0]          opened_reader,
    output logic                has_data
);
    import mrrb_pkg::*;

    localparam int PTR_W  = $clog2(SLOTS);
    localparam int RS_W   = (PTR_W + 1 > 5) ? PTR_W + 1 : 5;
    localparam int RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int RW_W   = RIDX_W + 3;
    localparam int GW_W   = RIDX_W + 2;
    localparam int LIM_W  = 5;

    typedef enum logic [1:0] {
        MODE_CLOSED,
        MODE_OPEN,
        MODE_OVERRUN
    } mode_t;

    logic [PTR_W-1:0]  write_slot_reg, write_slot_next;
    logic [PTR_W-1:0]  slot_reg [READERS];
    logic [PTR_W-1:0]  slot_next [READERS];
    mode_t             mode_reg [READERS];
    mode_t             mode_next [READERS];
    logic              res_valid_reg, res_valid_next;
    logic [2:0]        status_reg;
    logic [1:0]        opened_reg;
    logic              has_data_reg;
    logic              use_ram_reg;

    logic              exec;
    logic [RS_W-1:0]   cap_plus;
    logic [RS_W-1:0]   ring_size;
    logic [LIM_W-1:0]  lim;
    logic              r_in;
    logic [RW_W-1:0]   r_wide;
    logic [RIDX_W-1:0] r_idx;
    logic [PTR_W-1:0]  ahead;

    logic [2:0]        st;
    logic              use_ram;
    logic [RIDX_W-1:0] granted;
    logic [GW_W-1:0]   g_wide;
    logic              found;
    logic              hd_ok;
    logic              hd_in;
    logic [RIDX_W-1:0] hd_idx;
    logic              hd;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                   input logic [RS_W-1:0]  rs);
        logic [RS_W-1:0] n;
        n = RS_W'(p) + RS_W'(1);
        return (n >= rs) ? '0 : n[PTR_W-1:0];
    endfunction

    assign cap_plus  = RS_W'(cfg.capacity) + RS_W'(1);
    assign ring_size = (cap_plus > RS_W'(SLOTS)) ? RS_W'(SLOTS) : cap_plus;
    assign lim       = (LIM_W'(cfg.readers_in_use) > LIM_W'(READERS)) ?
                       LIM_W'(READERS) : LIM_W'(cfg.readers_in_use);
    assign r_in      = LIM_W'(q_ctl.reader) < lim;
    assign r_wide    = RW_W'(q_ctl.reader);
    assign r_idx     = r_wide[RIDX_W-1:0];
    assign ahead     = next_slot(write_slot_reg, ring_size);

    // result stage must be free or draining before a request executes
    assign exec  = q_valid && (!res_valid_reg || out_ready);
    assign q_pop = exec;

    always_comb
    begin
        write_slot_next = write_slot_reg;
        slot_next       = slot_reg;
        mode_next       = mode_reg;
        st              = ST_OK;
        use_ram         = 1'b0;
        granted         = '0;
        found           = 1'b0;
        hd_ok           = 1'b1;
        hd_in           = r_in;
        hd_idx          = r_idx;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = slot_reg[r_idx];
        if (exec)
        begin
            case (q_ctl.kind)
                K_PUSH:
                begin
                    // readers sitting just ahead of the writer get pushed along
                    for (int i = 0; i < READERS; i++)
                    begin
                        if (LIM_W'(i) < lim && slot_reg[i] == ahead)
                        begin
                            if (mode_reg[i] != MODE_CLOSED)
                            begin
                                mode_next[i] = MODE_OVERRUN;
                            end
                            slot_next[i] = next_slot(slot_reg[i], ring_size);
                        end
                    end
                    ram_wr_en       = 1'b1;
                    write_slot_next = ahead;
                end
                K_PEEK, K_POP:
                begin
                    if (!r_in || mode_reg[r_idx] == MODE_CLOSED)
                    begin
                        st = ST_INVALID;
                    end
                    else if (mode_reg[r_idx] == MODE_OVERRUN)
                    begin
                        mode_next[r_idx] = MODE_OPEN;
                        slot_next[r_idx] = ahead;
                        st               = ST_OVERRUN;
                    end
                    else if (slot_reg[r_idx] == write_slot_reg)
                    begin
                        st = ST_UNDERRUN;
                    end
                    else
                    begin
                        ram_rd_en = 1'b1;
                        use_ram   = 1'b1;
                        if (q_ctl.kind == K_POP)
                        begin
                            slot_next[r_idx] = next_slot(slot_reg[r_idx], ring_size);
                        end
                    end
                end
                K_OPEN:
                begin
                    st    = ST_NOFREE;
                    hd_ok = 1'b0;
                    for (int i = 0; i < READERS; i++)
                    begin
                        if (!found && LIM_W'(i) < lim && mode_reg[i] == MODE_CLOSED)
                        begin
                            found        = 1'b1;
                            mode_next[i] = MODE_OPEN;
                            granted      = RIDX_W'(i);
                        end
                    end
                    if (found)
                    begin
                        st     = ST_OK;
                        hd_ok  = 1'b1;
                        hd_in  = 1'b1;
                        hd_idx = granted;
                    end
                end
                K_CLOSE:
                begin
                    if (r_in)
                    begin
                        mode_next[r_idx] = MODE_CLOSED;
                    end
                    else
                    begin
                        st = ST_INVALID;
                    end
                end
                default:
                begin
                    st    = ST_INVALID;
                    hd_ok = 1'b0;
                end
            endcase
        end
    end

    assign g_wide = GW_W'(granted);
    assign hd     = hd_ok && hd_in && mode_next[hd_idx] != MODE_CLOSED &&
                    slot_next[hd_idx] != write_slot_next;

    always_comb
    begin
        if (exec)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            slot_reg       <= '{default: '0};
            mode_reg       <= '{default: MODE_CLOSED};
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            slot_reg       <= slot_next;
            mode_reg       <= mode_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg   <= st;
            opened_reg   <= g_wide[1:0];
            has_data_reg <= hd;
            use_ram_reg  <= use_ram;
        end
    end

    mrrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (q_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // RAM read data holds while the result waits: no read issues until it drains
    assign out_valid     = res_valid_reg;
    assign status        = status_reg;
    assign data_out      = use_ram_reg ? ram_rd_data : '0;
    assign opened_reader = opened_reg;
    assign has_data      = has_data_reg;

`ifndef ASSERT_OFF
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && status_reg != ST_OK |-> !use_ram_reg && opened_reg == 2'd0)
        else $error("failed request carries data or a granted slot");

    a_nofree_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && status_reg == ST_NOFREE |-> !has_data_reg)
        else $error("open with no free slot reports data");
`endif

endmodule

@@ sv/multi_reader_ring_buffer.sv @@
// Multi-reader ring buffer: one writer and several readers over a word ring.
// Usage:
//   Requests enter on in_valid/in_ready with opcode, reader and data_in
//   (push, peek, pop, open reader, close reader). Each request gives exactly
//   one result on out_valid/out_ready: status, data_out, opened_reader and
//   has_data.
//   Configuration (capacity, readers_in_use) is written on cfg_valid/cfg_ready
//   with cfg_index and cfg_data; the user must write it only while no request
//   is in flight, which is unchecked by the block. cfg_ready is always high.
//   An accepted request is registered in the request queue, then executes
//   from it, and its result is registered in the result stage.
//   Throughput: one request per cycle while the receiver takes results, set by
//   the single execute stage that reads and updates all reader state and issues
//   at most one RAM access. A two-entry request queue separates the decode
//   front end from execution; when the receiver stalls, the result holds, the
//   queue fills and in_ready drops once the queue holds two requests.
//   Reset clears the write slot, all reader positions and modes (all closed)
//   and sets capacity 15 and readers_in_use 4. Word RAM contents are not
//   cleared; a word never written reads as anything.
// Depends on mrrb_pkg, mrrb_front, mrrb_back, mrrb_ram.
module multi_reader_ring_buffer #(
    parameter int SLOTS   = 16,
    parameter int READERS = 4,
    parameter int DATA_W  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      opcode,
    input  logic [2:0]                      reader,
    input  logic [DATA_W-1:0]               data_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [DATA_W-1:0]               data_out,
    output logic [1:0]                      opened_reader,
    output logic                            has_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mrrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrrb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mrrb_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              q_valid;
    logic              q_pop;
    op_ctl_t           q_ctl;
    logic [DATA_W-1:0] q_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAPACITY: cfg_next.capacity       = cfg_data[3:0];
                CFG_READERS:  cfg_next.readers_in_use = cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity       <= CAPACITY_RESET;
            cfg_reg.readers_in_use <= READERS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mrrb_front #(
        .DATA_W (DATA_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .reader   (reader),
        .data_in  (data_in),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_ctl    (q_ctl),
        .q_data   (q_data)
    );

    mrrb_back #(
        .SLOTS   (SLOTS),
        .READERS (READERS),
        .DATA_W  (DATA_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_ctl         (q_ctl),
        .q_data        (q_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_out      (data_out),
        .opened_reader (opened_reader),
        .has_data      (has_data)
    );

endmodule

@@ tb/sv/ring_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the multi-reader ring buffer: a predictor of the ring and reader state,
// plus the queue of expected results. Depends on mrrb_pkg.
package ring_check_pkg;
    import mrrb_pkg::*;

    localparam int SLOTS   = 16;
    localparam int READERS = 4;
    localparam int DATA_W  = 32;

    localparam logic [2:0] OP_LAST = 3'd7;

    typedef enum logic [1:0] {
        MODE_CLOSED,
        MODE_OPEN,
        MODE_OVERRUN
    } reader_mode_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] word;
        logic [1:0]        granted;
        logic              has_data;
    } ring_result_t;

    class ring_scoreboard;
        logic [DATA_W-1:0] words [SLOTS];
        bit                written [SLOTS];
        int                wr_slot;
        int                rd_slot [READERS];
        reader_mode_t      mode [READERS];
        int                capacity;
        int                readers_in_use;
        ring_result_t      expected_q [$];
        int                mismatches;
        int                requests;
        int                checked;
        int                overruns;
        int                underruns;
        int                invalids;
        int                returned;

        function new();
            wr_slot = 0;
            capacity = CAPACITY_RESET;
            readers_in_use = READERS_RESET;
            foreach (rd_slot[i])
            begin
                rd_slot[i] = 0;
                mode[i] = MODE_CLOSED;
            end
            foreach (written[i])
                written[i] = 0;
            mismatches = 0;
            requests = 0;
            checked = 0;
            overruns = 0;
            underruns = 0;
            invalids = 0;
            returned = 0;
        endfunction

        function int ring_size();
            return (capacity + 1 > SLOTS) ? SLOTS : capacity + 1;
        endfunction

        function int reader_limit();
            return (readers_in_use > READERS) ? READERS : readers_in_use;
        endfunction

        function int next_slot(int p);
            return (p + 1 >= ring_size()) ? 0 : p + 1;
        endfunction

        function bit has_data_of(int r);
            if (r >= reader_limit())
                return 0;
            return mode[r] != MODE_CLOSED && rd_slot[r] != wr_slot;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_CAPACITY)
                capacity = value;
            else if (idx == CFG_READERS)
                readers_in_use = value[2:0];
        endfunction

        // True when this request would fetch a ring word that was never stored.
        function bit reads_unwritten(logic [2:0] op, logic [2:0] rd);
            int r;
            r = rd;
            if (op != OP_PEEK && op != OP_POP)
                return 0;
            if (r >= reader_limit() || mode[r] != MODE_OPEN || rd_slot[r] == wr_slot)
                return 0;
            return !written[rd_slot[r]];
        endfunction

        function void note(logic [2:0] op, logic [2:0] rd, logic [DATA_W-1:0] word);
            ring_result_t res;
            int           r;
            int           ahead;
            int           hd_reader;
            bit           hd_valid;
            r = rd;
            res = '0;
            hd_reader = r;
            hd_valid = 1;
            requests++;
            case (op)
                OP_PUSH:
                begin
                    ahead = next_slot(wr_slot);
                    // readers sitting on the slot just ahead of the write slot get shoved along
                    for (int i = 0; i < reader_limit(); i++)
                    begin
                        if (rd_slot[i] == ahead)
                        begin
                            if (mode[i] != MODE_CLOSED)
                                mode[i] = MODE_OVERRUN;
                            rd_slot[i] = next_slot(rd_slot[i]);
                        end
                    end
                    words[wr_slot] = word;
                    written[wr_slot] = 1;
                    wr_slot = ahead;
                end
                OP_PEEK, OP_POP:
                begin
                    if (r >= reader_limit() || mode[r] == MODE_CLOSED)
                        res.status = ST_INVALID;
                    else if (mode[r] == MODE_OVERRUN)
                    begin
                        mode[r] = MODE_OPEN;
                        rd_slot[r] = next_slot(wr_slot);
                        res.status = ST_OVERRUN;
                    end
                    else if (rd_slot[r] == wr_slot)
                        res.status = ST_UNDERRUN;
                    else
                    begin
                        res.word = words[rd_slot[r]];
                        returned++;
                        if (op == OP_POP)
                            rd_slot[r] = next_slot(rd_slot[r]);
                    end
                end
                OP_OPEN:
                begin
                    res.status = ST_NOFREE;
                    hd_valid = 0;
                    for (int i = 0; i < reader_limit(); i++)
                    begin
                        if (!hd_valid && mode[i] == MODE_CLOSED)
                        begin
                            mode[i] = MODE_OPEN;
                            res.granted = 2'(i);
                            hd_reader = i;
                            hd_valid = 1;
                            res.status = ST_OK;
                        end
                    end
                end
                OP_CLOSE:
                begin
                    if (r < reader_limit())
                        mode[r] = MODE_CLOSED;
                    else
                        res.status = ST_INVALID;
                end
                default:
                begin
                    res.status = ST_INVALID;
                    hd_valid = 0;
                end
            endcase
            res.has_data = hd_valid && has_data_of(hd_reader);
            if (res.status == ST_OVERRUN)
                overruns++;
            if (res.status == ST_UNDERRUN)
                underruns++;
            if (res.status == ST_INVALID)
                invalids++;
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30)
                $display("MISMATCH: %s", msg);
        endtask

        task check(ring_result_t got);
            ring_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.word !== want.word)
                report($sformatf("result %0d data_out %h, want %h",
                                 checked, got.word, want.word));
            if (got.granted !== want.granted)
                report($sformatf("result %0d opened_reader %0d, want %0d",
                                 checked, got.granted, want.granted));
            if (got.has_data !== want.has_data)
                report($sformatf("result %0d has_data %b, want %b",
                                 checked, got.has_data, want.has_data));
        endtask
    endclass

endpackage

@@ tb/sv/multi_reader_ring_buffer_test.sv @@
`timescale 1ns / 1ps
// Top-level test of multi_reader_ring_buffer: directed requests, then random phases under
// several register settings, checked by ring_scoreboard. Depends on mrrb_pkg, ring_check_pkg.
module multi_reader_ring_buffer_test;
    import mrrb_pkg::*;
    import ring_check_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 64;
    localparam int STALL_LIMIT    = 1000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 105;
    localparam int PRESSURE_PHASE = 3;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            opcode = OP_PUSH;
    logic [2:0]            reader = 3'd0;
    logic [DATA_W-1:0]     data_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            status;
    logic [DATA_W-1:0]     data_out;
    logic [1:0]            opened_reader;
    logic                  has_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ring_scoreboard sb;
    bit             hold_request = 0;
    int             phase_cap [PHASES] = '{0, 1, 3, 15, 2, 7, 1, 4, 15, 5};
    int             phase_rdrs [PHASES] = '{4, 1, 2, 4, 3, 4, 4, 0, 7, 2};
    int             stall_pct [6] = '{0, 0, 15, 40, 70, 90};

    multi_reader_ring_buffer #(
        .SLOTS   (SLOTS),
        .READERS (READERS),
        .DATA_W  (DATA_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .reader        (reader),
        .data_in       (data_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_out      (data_out),
        .opened_reader (opened_reader),
        .has_data      (has_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Monitor: everything accepted at a rising edge goes to the scoreboard.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note(opcode, reader, data_in);
        if (out_valid && out_ready)
            sb.check({status, data_out, opened_reader, has_data});
        if (cfg_valid && cfg_ready)
            sb.set_register(cfg_index, cfg_data);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: stalls at a rate drawn at random from stall_pct; one long hold-off on request.
    initial
    begin : receiver
        int pct;
        wait (rst_n === 1'b1);
        forever
        begin
            pct = stall_pct[$urandom_range(0, 5)];
            for (int k = 0; k < 32; k++)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                else
                    out_ready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    // Entered and left at a falling edge; valid stays up between back-to-back requests.
    task automatic offer(input logic [2:0] op, input logic [2:0] rd, input logic [DATA_W-1:0] word);
        // a ring word that was never stored must not be fetched
        if (sb.reads_unwritten(op, rd))
            op = OP_PUSH;
        in_valid <= 1'b1;
        opcode <= op;
        reader <= rd;
        data_in <= word;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(input int count, input bit steady);
        int               left;
        int               burst;
        int               pick;
        logic [2:0]       op;
        logic [2:0]       rd;
        logic [DATA_W-1:0] word;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 36)
                    op = OP_PUSH;
                else if (pick < 52)
                    op = OP_PEEK;
                else if (pick < 80)
                    op = OP_POP;
                else if (pick < 88)
                    op = OP_OPEN;
                else if (pick < 95)
                    op = OP_CLOSE;
                else
                    op = 3'($urandom_range(OP_CLOSE + 1, OP_LAST));
                // mostly usable reader slots, sometimes anything the field holds
                rd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(0, 3));
                pick = $urandom_range(0, 19);
                word = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
                offer(op, rd, word);
                burst--;
                left--;
            end
            if (!steady && left > 0 && $urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings (capacity 15, four readers).
        offer(OP_PEEK, 3'd0, '0);               // closed reader
        offer(OP_OPEN, 3'd0, '0);
        offer(OP_PEEK, 3'd0, '0);               // empty
        offer(OP_POP, 3'd0, '0);
        offer(OP_PUSH, 3'd0, '0);
        offer(OP_PUSH, 3'd0, '1);
        offer(OP_OPEN, 3'd7, '0);
        offer(OP_OPEN, 3'd0, '0);
        offer(OP_OPEN, 3'd0, '0);
        offer(OP_OPEN, 3'd0, '0);               // all slots taken
        offer(OP_PEEK, 3'd0, '1);
        offer(OP_POP, 3'd0, '0);
        offer(OP_POP, 3'd0, '0);
        offer(OP_POP, 3'd0, '0);                // drained
        offer(OP_PEEK, 3'd7, '0);               // out of range
        offer(OP_CLOSE, 3'd5, '0);
        offer(OP_CLOSE + 3'd1, 3'd2, '1);       // undefined opcodes
        offer(OP_LAST, 3'd1, '1);
        offer(OP_CLOSE, 3'd1, '0);
        offer(OP_OPEN, 3'd0, '0);               // reopen keeps its position
        offer(OP_POP, 3'd1, '0);
        offer(OP_PUSH, 3'd3, 32'h8000_0001);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            write_reg(CFG_CAPACITY, CFG_DATA_W'(phase_cap[phase]));
            write_reg(CFG_READERS, CFG_DATA_W'(phase_rdrs[phase]));
            cfg_valid <= 1'b0;
            @(negedge clk);
            if (phase == PRESSURE_PHASE)
                hold_request = 1;
            run_random(PHASE_ITEMS, phase == PRESSURE_PHASE || phase % 4 == 1);
        end

        settle();
        while (sb.pending() != 0)
            sb.report("expected result never arrived");
        $display("covered %0d requests, %0d results checked, over %0d register settings",
                 sb.requests, sb.checked, PHASES + 1);
        $display("results: %0d words returned, %0d overruns, %0d underruns, %0d invalid",
                 sb.returned, sb.overruns, sb.underruns, sb.invalids);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
